FILE: rtl/core/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants for the indexed max-heap unit
// Operation and status codes, default sizes, sequencer states.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned MaxIdsDef  = 256;
  localparam int unsigned KeyBitsDef = 32;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_DEACT  = 3'd2;
  localparam logic [2:0] OP_MODIFY = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MAPRD, S_DECIDE, S_PUSHWR,
    S_RMRD, S_RMWR,
    S_DNRD, S_DNCMP, S_DNSWP,
    S_UPRD, S_UPCMP, S_UPSWP,
    S_FINRD, S_FINMAP, S_FINKEY, S_OUT
  } state_e;

endpackage

FILE: rtl/core/imh_ram.sv
// ----------------------------------------------------------------------------
// imh_ram: generic single-port RAM
// One address per cycle: an optional write and a registered read of the old data.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/core/indexed_max_heap_unit.sv
// ----------------------------------------------------------------------------
// indexed_max_heap_unit: indexed binary max-heap priority queue
// Heap of signed keys tagged by ids, slot map from id to heap slot.
// ----------------------------------------------------------------------------
// Push ends with a sift-up pass, pop and deactivate with a sift-down pass, and
//   modify with a sift-down pass followed by a sift-up pass.
// Throughput: one item at a time; a waiting result beat does not block input.
// Reset: a clearing pass over every slot-map entry zeroes the map with in_ready_o
//   low; clear runs the same pass after its result is loaded.
module indexed_max_heap_unit #(
  parameter int unsigned MaxIds  = imh_pkg::MaxIdsDef,
  parameter int unsigned KeyBits = imh_pkg::KeyBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  item_id_i,
  input  logic signed [31:0] priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  removed_id_o,
  output logic signed [31:0] removed_priority_o,
  output logic        top_present_o,
  output logic [7:0]  top_id_o,
  output logic signed [31:0] top_priority_o,
  output logic [8:0]  item_count_o,
  output logic        id_known_o,
  output logic        id_active_o,
  output logic signed [31:0] id_priority_o
);
  localparam int unsigned AW = $clog2(MaxIds);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned MW = AW + 2;
  localparam int unsigned IW = (AW > 0) ? AW : 1;
  localparam int unsigned KW = (KeyBits < 32) ? KeyBits : 32;

  typedef logic [AW-1:0] slot_t;

  // key RAM holds KW-bit signed values; compares are signed
  logic          kwe, iwe, mwe;
  slot_t         kaddr, iaddr;
  logic [IW-1:0] maddr;
  logic [KW-1:0] kwd, krd;
  logic [7:0]    iwd, ird;
  logic [MW-1:0] mwd, mrd;

  imh_ram #(.Width(KW), .Depth(MaxIds)) u_keys (
    .clk_i, .we_i(kwe), .addr_i(kaddr), .wdata_i(kwd), .rdata_o(krd));
  imh_ram #(.Width(8), .Depth(MaxIds)) u_ids (
    .clk_i, .we_i(iwe), .addr_i(iaddr), .wdata_i(iwd), .rdata_o(ird));
  imh_ram #(.Width(MW), .Depth(MaxIds)) u_map (
    .clk_i, .we_i(mwe), .addr_i(maddr[AW-1:0]), .wdata_i(mwd), .rdata_o(mrd));

  imh_pkg::state_e st_q, st_d;
  logic [CW-1:0] occ_q, occ_d, clr_q, clr_d;
  logic [2:0]  op_q, op_d, stat_q, stat_d;
  logic [7:0]  id_q, id_d;
  logic        idok_q, idok_d;
  logic [KW-1:0] key_q, key_d;
  slot_t       cur_q, cur_d, oth_q, oth_d;
  logic [KW-1:0] ck_q, ck_d, ok_q, ok_d;
  logic [7:0]  ci_q, ci_d, oi_q, oi_d;
  logic [1:0]  ph_q, ph_d;
  logic        up_after_q, up_after_d;
  logic [7:0]  rid_q, rid_d;
  logic [KW-1:0] rkey_q, rkey_d;
  logic [MW-1:0] qm_q, qm_d;
  logic        ov_q;
  // modify: slot it started from and the key left there after sinking
  slot_t       pos_q, pos_d;
  logic [KW-1:0] pk_q, pk_d;

  // output register
  logic [2:0]  o_stat_q, o_stat_d;
  logic [7:0]  o_rid_q, o_rid_d, o_tid_q, o_tid_d;
  logic [31:0] o_rp_q, o_rp_d, o_tp_q, o_tp_d, o_ip_q, o_ip_d;
  logic        o_tpres_q, o_tpres_d, o_kn_q, o_kn_d, o_ac_q, o_ac_d;
  logic [8:0]  o_cnt_q, o_cnt_d;
  logic        o_load;

  // shared comparator: signed compare of two keys
  logic [KW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  function automatic logic [31:0] sx(input logic [KW-1:0] k);
    return 32'($signed(k));
  endfunction

  wire accept  = in_valid_i && in_ready_o;
  wire in_idok = 32'(item_id_i) < MaxIds;
  assign in_ready_o = (st_q == imh_pkg::S_IDLE);

  // result register may still hold an untaken beat; stall before reloading
  wire out_free = !ov_q || out_ready_i;

  wire slot_t last = slot_t'(occ_q - CW'(1));
  wire [CW:0] lidx = {1'b0, cur_q, 1'b1};
  wire [CW:0] ridx = lidx + (CW+1)'(1);

  always_comb begin
    st_d = st_q; occ_d = occ_q; clr_d = clr_q; op_d = op_q; stat_d = stat_q;
    id_d = id_q; idok_d = idok_q; key_d = key_q; cur_d = cur_q; oth_d = oth_q;
    ck_d = ck_q; ok_d = ok_q; ci_d = ci_q; oi_d = oi_q; ph_d = ph_q;
    up_after_d = up_after_q; rid_d = rid_q; rkey_d = rkey_q; qm_d = qm_q;
    pos_d = pos_q; pk_d = pk_q;
    kwe = 1'b0; iwe = 1'b0; mwe = 1'b0;
    kaddr = cur_q; iaddr = cur_q; maddr = IW'(id_q);
    kwd = ck_q; iwd = ci_q; mwd = '0;
    cmp_a = ck_q; cmp_b = ok_q;
    o_load = 1'b0;
    unique case (st_q)
      imh_pkg::S_INIT: begin
        mwe = 1'b1; maddr = IW'(clr_q); mwd = '0;
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(MaxIds - 1)) st_d = imh_pkg::S_IDLE;
      end
      imh_pkg::S_IDLE: begin
        if (accept) begin
          op_d = operation_i; id_d = item_id_i; idok_d = in_idok;
          key_d = priority_req_i[KW-1:0];
          stat_d = imh_pkg::ST_OK; rid_d = '0; rkey_d = '0;
          maddr = IW'(item_id_i);
          st_d = imh_pkg::S_MAPRD;
        end
      end
      imh_pkg::S_MAPRD: st_d = imh_pkg::S_DECIDE;
      imh_pkg::S_DECIDE: begin
        st_d = imh_pkg::S_FINRD;
        priority case (op_q)
          imh_pkg::OP_PUSH: begin
            if (!idok_q) stat_d = imh_pkg::ST_ABSENT;
            else if (mrd > MW'(1)) stat_d = imh_pkg::ST_PRESENT;
            else if (occ_q >= CW'(MaxIds)) stat_d = imh_pkg::ST_FULL;
            else begin
              cur_d = slot_t'(occ_q); ck_d = key_q; ci_d = id_q;
              st_d = imh_pkg::S_PUSHWR;
            end
          end
          imh_pkg::OP_POP, imh_pkg::OP_DEACT: begin
            if (occ_q == '0) stat_d = imh_pkg::ST_EMPTY;
            else begin
              cur_d = '0; ph_d = 2'd0; st_d = imh_pkg::S_RMRD;
            end
          end
          imh_pkg::OP_MODIFY: begin
            if (!idok_q || mrd < MW'(2) || (mrd - MW'(2)) >= MW'(occ_q))
              stat_d = imh_pkg::ST_ABSENT;
            else begin
              cur_d = slot_t'(mrd - MW'(2)); ck_d = key_q;
              pos_d = slot_t'(mrd - MW'(2)); pk_d = key_q;
              kwe = 1'b1; kaddr = slot_t'(mrd - MW'(2)); kwd = key_q;
              up_after_d = 1'b1; ph_d = 2'd0;
              st_d = imh_pkg::S_DNRD;
            end
          end
          imh_pkg::OP_CLEAR: begin
            occ_d = '0; clr_d = '0; st_d = imh_pkg::S_INIT;
            o_load = 1'b0;
          end
          default: ;
        endcase
        if (op_q == imh_pkg::OP_CLEAR) st_d = imh_pkg::S_OUT;
      end
      imh_pkg::S_PUSHWR: begin
        kwe = 1'b1; iwe = 1'b1; mwe = 1'b1;
        mwd = MW'(cur_q) + MW'(2);
        occ_d = occ_q + CW'(1);
        up_after_d = 1'b0; ph_d = 2'd0;
        st_d = imh_pkg::S_UPRD;
      end
      // remove top: read slot 0 and last, write last into 0
      imh_pkg::S_RMRD: begin
        ph_d = ph_q + 2'd1;
        kaddr = (ph_q == 2'd0) ? '0 : last; iaddr = kaddr;
        if (ph_q == 2'd1) begin rkey_d = krd; rid_d = ird; end
        if (ph_q == 2'd2) begin
          ck_d = krd; ci_d = ird; ph_d = 2'd0; st_d = imh_pkg::S_RMWR;
        end
      end
      imh_pkg::S_RMWR: begin
        kwe = 1'b1; iwe = 1'b1; kaddr = '0; iaddr = '0;
        mwe = 1'b1;
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          maddr = IW'(ci_q); mwd = MW'(2);
        end else begin
          maddr = IW'(rid_q);
          mwd = (op_q == imh_pkg::OP_POP) ? MW'(0) : MW'(1);
          ph_d = 2'd3;
          if (last == '0) begin
            occ_d = occ_q - CW'(1);
            st_d = imh_pkg::S_FINRD; ph_d = 2'd0;
          end
        end
        if (ph_q == 2'd3) begin
          occ_d = occ_q - CW'(1); cur_d = '0; up_after_d = 1'b0; ph_d = 2'd0;
          st_d = imh_pkg::S_DNRD;
        end
      end
      // sift down: read left, right children
      imh_pkg::S_DNRD: begin
        if (lidx >= (CW+1)'(occ_q)) begin
          st_d = up_after_q ? imh_pkg::S_UPRD : imh_pkg::S_FINRD; ph_d = 2'd0;
          // modify climbs from the slot it started at
          if (up_after_q) begin cur_d = pos_q; ck_d = pk_q; end
        end else begin
          ph_d = ph_q + 2'd1;
          kaddr = (ph_q == 2'd0) ? slot_t'(lidx) : slot_t'(ridx); iaddr = kaddr;
          if (ph_q == 2'd1) begin ok_d = krd; oi_d = ird; oth_d = slot_t'(lidx); end
          if (ph_q == 2'd2) begin
            st_d = imh_pkg::S_DNCMP; ph_d = 2'd0;
            if (ridx != (CW+1)'(occ_q)) begin
              cmp_a = ok_q; cmp_b = krd;
              if (cmp_lt) begin ok_d = krd; oi_d = ird; oth_d = slot_t'(ridx); end
            end
          end
        end
      end
      imh_pkg::S_DNCMP: begin
        cmp_a = ck_q; cmp_b = ok_q;
        if (cmp_lt) begin ph_d = 2'd0; st_d = imh_pkg::S_DNSWP; end
        else begin
          st_d = up_after_q ? imh_pkg::S_UPRD : imh_pkg::S_FINRD;
          if (up_after_q) begin cur_d = pos_q; ck_d = pk_q; end
        end
        iaddr = cur_q;
        if (up_after_q) ci_d = ci_q;
      end
      // swap cur (ck,ci) with oth (ok,oi); ci of modify item unknown: read it
      imh_pkg::S_DNSWP, imh_pkg::S_UPSWP: begin
        ph_d = ph_q + 2'd1;
        unique case (ph_q)
          2'd0: begin iaddr = cur_q; end
          2'd1: begin
            ci_d = ird;
            kwe = 1'b1; iwe = 1'b1; kaddr = cur_q; iaddr = cur_q;
            kwd = ok_q; iwd = oi_q;
            mwe = 1'b1; maddr = IW'(oi_q); mwd = MW'(cur_q) + MW'(2);
            if (st_q == imh_pkg::S_DNSWP && cur_q == pos_q) pk_d = ok_q;
          end
          2'd2: begin
            kwe = 1'b1; iwe = 1'b1; kaddr = oth_q; iaddr = oth_q;
            kwd = ck_q; iwd = ci_q;
            mwe = 1'b1; maddr = IW'(ci_q); mwd = MW'(oth_q) + MW'(2);
            cur_d = oth_q; ph_d = 2'd0;
            st_d = (st_q == imh_pkg::S_DNSWP) ? imh_pkg::S_DNRD : imh_pkg::S_UPRD;
          end
          default: ;
        endcase
      end
      imh_pkg::S_UPRD: begin
        if (cur_q == '0) st_d = imh_pkg::S_FINRD;
        else begin
          kaddr = slot_t'((cur_q - slot_t'(1)) >> 1); iaddr = kaddr;
          oth_d = kaddr; ph_d = 2'd0; st_d = imh_pkg::S_UPCMP;
        end
      end
      imh_pkg::S_UPCMP: begin
        iaddr = oth_q; kaddr = oth_q;
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd0) begin
          ok_d = krd; oi_d = ird; cmp_a = ck_q; cmp_b = krd;
          if (cmp_lt) st_d = imh_pkg::S_FINRD;
          else begin ph_d = 2'd0; st_d = imh_pkg::S_UPSWP; end
        end
      end
      imh_pkg::S_FINRD: begin
        maddr = IW'(id_q); kaddr = '0; iaddr = '0;
        st_d = imh_pkg::S_FINMAP;
      end
      imh_pkg::S_FINMAP: begin
        ok_d = krd; oi_d = ird; qm_d = mrd;
        kaddr = slot_t'(mrd - MW'(2));
        st_d = imh_pkg::S_FINKEY;
      end
      imh_pkg::S_FINKEY: begin
        // hold the queried key on the read port until the result loads
        kaddr = slot_t'(qm_q - MW'(2));
        if (out_free) begin
          o_load = 1'b1; st_d = imh_pkg::S_IDLE;
        end
      end
      imh_pkg::S_OUT: begin
        if (out_free) begin
          o_load = 1'b1; st_d = imh_pkg::S_INIT;
        end
      end
      default: st_d = imh_pkg::S_IDLE;
    endcase
  end

  // result fields
  wire act = idok_q && (qm_q > MW'(1)) && ((qm_q - MW'(2)) < MW'(occ_q));
  wire clr_op = (st_q == imh_pkg::S_OUT);
  always_comb begin
    o_stat_d  = stat_q;
    o_rid_d   = rid_q;
    o_rp_d    = (rid_q != '0 || rkey_q != '0) ? sx(rkey_q) : '0;
    o_tpres_d = !clr_op && occ_q != '0;
    o_tid_d   = o_tpres_d ? oi_q : '0;
    o_tp_d    = o_tpres_d ? sx(ok_q) : '0;
    o_cnt_d   = clr_op ? '0 : 9'(occ_q);
    o_kn_d    = !clr_op && idok_q && qm_q != '0;
    o_ac_d    = !clr_op && act;
    o_ip_d    = o_ac_d ? sx(krd) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= imh_pkg::S_INIT; occ_q <= '0; clr_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; occ_q <= occ_d; clr_q <= clr_d;
      if (o_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; stat_q <= stat_d; id_q <= id_d; idok_q <= idok_d;
    key_q <= key_d; cur_q <= cur_d; oth_q <= oth_d; ck_q <= ck_d; ok_q <= ok_d;
    ci_q <= ci_d; oi_q <= oi_d; ph_q <= ph_d; up_after_q <= up_after_d;
    rid_q <= rid_d; rkey_q <= rkey_d; qm_q <= qm_d;
    pos_q <= pos_d; pk_q <= pk_d;
    if (o_load) begin
      o_stat_q <= o_stat_d; o_rid_q <= o_rid_d; o_rp_q <= o_rp_d;
      o_tpres_q <= o_tpres_d; o_tid_q <= o_tid_d; o_tp_q <= o_tp_d;
      o_cnt_q <= o_cnt_d; o_kn_q <= o_kn_d; o_ac_q <= o_ac_d; o_ip_q <= o_ip_d;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = o_stat_q; assign removed_id_o = o_rid_q;
  assign removed_priority_o = o_rp_q; assign top_present_o = o_tpres_q;
  assign top_id_o = o_tid_q; assign top_priority_o = o_tp_q;
  assign item_count_o = o_cnt_q; assign id_known_o = o_kn_q;
  assign id_active_o = o_ac_q; assign id_priority_o = o_ip_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("accepted while busy");
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(MaxIds)) else $error("occupancy overflow");
  a_active_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && id_active_o |-> id_known_o) else $error("active not known");
  a_count_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_present_o == (item_count_o != '0)))
    else $error("top vs count");
endmodule

FILE: sim/indexed_max_heap_unit_test.sv
// ----------------------------------------------------------------------------
// indexed_max_heap_unit_test: self-checking bench for the indexed max-heap
// Drives push, pop, deactivate, modify, clear and query beats with random
// gaps on both channels, predicts every result beat with a behavioral heap
// and compares the result field by field.
// ----------------------------------------------------------------------------
module indexed_max_heap_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumIds   = 256;
  localparam logic [2:0]  OpQuery  = 3'd5;
  localparam int          RunLimit = 400000;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         id;
    logic signed [31:0] prio;
  } op_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         removed_id;
    logic signed [31:0] removed_prio;
    logic               top_present;
    logic [7:0]         top_id;
    logic signed [31:0] top_prio;
    logic [8:0]         count;
    logic               known;
    logic               active;
    logic signed [31:0] id_prio;
  } heap_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] operation_i = '0;
  logic [7:0] item_id_i = '0;
  logic signed [31:0] priority_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [7:0] removed_id_o;
  logic signed [31:0] removed_priority_o;
  logic top_present_o;
  logic [7:0] top_id_o;
  logic signed [31:0] top_priority_o;
  logic [8:0] item_count_o;
  logic id_known_o;
  logic id_active_o;
  logic signed [31:0] id_priority_o;

  indexed_max_heap_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state: keys, ids, slot map (0 absent, 1 deactivated, s+2 slot s)
  logic signed [31:0] mdl_keys [NumIds];
  logic [7:0]         mdl_ids  [NumIds];
  int unsigned        mdl_slot [NumIds];
  int unsigned        mdl_count;

  op_beat_t   pending_ops [$];
  heap_view_t expected_views [$];
  int         n_errors;
  int         n_results;
  int         cycle_count;
  bit         stim_done;
  bit         calm;    // no idling while set
  bit         in_taken = 1'b0;  // input beat accepted at the last rising edge

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic signed [31:0] tk;
    logic [7:0] ia, ib;
    if (a == b) return;
    tk = mdl_keys[a]; mdl_keys[a] = mdl_keys[b]; mdl_keys[b] = tk;
    ia = mdl_ids[a]; ib = mdl_ids[b];
    mdl_slot[ia] = b + 2; mdl_slot[ib] = a + 2;
    mdl_ids[a] = ib; mdl_ids[b] = ia;
  endfunction

  // Climb while the child is not strictly below its parent.
  function automatic void sift_up(int unsigned e);
    int unsigned p;
    while (e != 0) begin
      p = (e - 1) / 2;
      if (mdl_keys[e] < mdl_keys[p]) break;
      swap_slots(e, p);
      e = p;
    end
  endfunction

  // Sink toward the larger child; left wins ties.
  function automatic void sift_down(int unsigned h);
    int unsigned l, c;
    forever begin
      l = 2 * h + 1;
      if (l >= mdl_count) break;
      c = (l + 1 == mdl_count || mdl_keys[l] >= mdl_keys[l + 1]) ? l : l + 1;
      if (mdl_keys[h] < mdl_keys[c]) begin
        swap_slots(h, c);
        h = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic heap_view_t apply_heap_op(op_beat_t b);
    heap_view_t v;
    int unsigned s, m;
    v = '0;
    v.status = imh_pkg::ST_OK;
    case (b.op)
      imh_pkg::OP_PUSH: begin
        if (mdl_slot[b.id] > 1) v.status = imh_pkg::ST_PRESENT;
        else if (mdl_count >= NumIds) v.status = imh_pkg::ST_FULL;
        else begin
          s = mdl_count;
          mdl_keys[s] = b.prio;
          mdl_ids[s] = b.id;
          mdl_slot[b.id] = s + 2;
          mdl_count++;
          sift_up(s);
        end
      end
      imh_pkg::OP_POP, imh_pkg::OP_DEACT: begin
        if (mdl_count == 0) v.status = imh_pkg::ST_EMPTY;
        else begin
          v.removed_id = mdl_ids[0];
          v.removed_prio = mdl_keys[0];
          swap_slots(0, mdl_count - 1);
          mdl_count--;
          mdl_slot[v.removed_id] = (b.op == imh_pkg::OP_POP) ? 0 : 1;
          sift_down(0);
        end
      end
      imh_pkg::OP_MODIFY: begin
        if (mdl_slot[b.id] < 2 || mdl_slot[b.id] - 2 >= mdl_count)
          v.status = imh_pkg::ST_ABSENT;
        else begin
          s = mdl_slot[b.id] - 2;
          mdl_keys[s] = b.prio;
          sift_down(s);
          sift_up(s);
        end
      end
      imh_pkg::OP_CLEAR: begin
        foreach (mdl_slot[i]) mdl_slot[i] = 0;
        mdl_count = 0;
      end
      default: ;
    endcase
    if (mdl_count != 0) begin
      v.top_present = 1'b1;
      v.top_id = mdl_ids[0];
      v.top_prio = mdl_keys[0];
    end
    v.count = mdl_count[8:0];
    m = mdl_slot[b.id];
    v.known = (m != 0);
    if (m > 1 && m - 2 < mdl_count) begin
      v.active = 1'b1;
      v.id_prio = mdl_keys[m - 2];
    end
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    n_errors++;
    $display("result %0d: %s got %0h want %0h", n_results, field, got, want);
  endtask

  function automatic logic signed [31:0] rand_prio();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 7))) - 4;   // frequent ties
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(logic [2:0] op, logic [7:0] id, logic signed [31:0] prio);
    pending_ops.push_back(op_beat_t'{op: op, id: id, prio: prio});
  endtask

  // Driver: present beats at the falling edge, hold until accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
          {operation_i, item_id_i, priority_req_i} <= pending_ops.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // Predict on accepted input beats, check on accepted result beats.
  always @(posedge clk_i) begin
    heap_view_t want, got;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o)
        expected_views.push_back(apply_heap_op({operation_i, item_id_i, priority_req_i}));
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, removed_id_o, removed_priority_o, top_present_o, top_id_o,
                top_priority_o, item_count_o, id_known_o, id_active_o, id_priority_o};
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_views.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.removed_id !== want.removed_id)
            report_mismatch("removed_id", got.removed_id, want.removed_id);
          if (got.removed_prio !== want.removed_prio)
            report_mismatch("removed_priority", got.removed_prio, want.removed_prio);
          if (got.top_present !== want.top_present)
            report_mismatch("top_present", got.top_present, want.top_present);
          if (got.top_id !== want.top_id) report_mismatch("top_id", got.top_id, want.top_id);
          if (got.top_prio !== want.top_prio)
            report_mismatch("top_priority", got.top_prio, want.top_prio);
          if (got.count !== want.count) report_mismatch("item_count", got.count, want.count);
          if (got.known !== want.known) report_mismatch("id_known", got.known, want.known);
          if (got.active !== want.active) report_mismatch("id_active", got.active, want.active);
          if (got.id_prio !== want.id_prio)
            report_mismatch("id_priority", got.id_prio, want.id_prio);
        end
        n_results <= n_results + 1;
      end
      if (cycle_count > RunLimit) begin
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 expected_views.size());
        $display("indexed_max_heap_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    logic [7:0] id;
    foreach (mdl_slot[i]) mdl_slot[i] = 0;
    mdl_count = 0;
    n_errors = 0; n_results = 0; cycle_count = 0; stim_done = 0; calm = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty-heap removals, extreme keys, ties, duplicates, modify
    // both ways, deactivate then re-push, clear, out-of-range operation codes.
    add_op(imh_pkg::OP_POP, 8'd0, 0);
    add_op(imh_pkg::OP_DEACT, 8'd255, 0);
    add_op(imh_pkg::OP_MODIFY, 8'd7, 5);
    add_op(imh_pkg::OP_PUSH, 8'd0, 32'sh80000000);
    add_op(imh_pkg::OP_PUSH, 8'd255, 32'sh7fffffff);
    add_op(imh_pkg::OP_PUSH, 8'd1, 32'sh7fffffff);
    add_op(imh_pkg::OP_PUSH, 8'd2, 0);
    add_op(imh_pkg::OP_PUSH, 8'd3, 0);
    add_op(imh_pkg::OP_PUSH, 8'd1, 9);
    add_op(imh_pkg::OP_MODIFY, 8'd255, -1);
    add_op(imh_pkg::OP_MODIFY, 8'd0, 32'sh7fffffff);
    add_op(OpQuery, 8'd255, 0);
    add_op(imh_pkg::OP_DEACT, 8'd0, 0);
    add_op(OpQuery, 8'd0, 0);
    add_op(imh_pkg::OP_MODIFY, 8'd0, 1);
    add_op(imh_pkg::OP_PUSH, 8'd0, -5);
    add_op(imh_pkg::OP_POP, 8'd3, 0);
    add_op(3'd6, 8'd2, 32'hffffffff);
    add_op(3'd7, 8'd170, 32'h55555555);
    add_op(imh_pkg::OP_CLEAR, 8'd2, 0);
    add_op(OpQuery, 8'd2, 0);
    add_op(imh_pkg::OP_POP, 8'd0, 0);

    // Fill to the full mark, then push twice more, pop once and push again.
    calm = 1;
    for (int i = 0; i < 256; i++) add_op(imh_pkg::OP_PUSH, i[7:0], rand_prio());
    add_op(imh_pkg::OP_PUSH, 8'd9, 1);
    add_op(imh_pkg::OP_PUSH, 8'd9, 1);
    add_op(imh_pkg::OP_POP, 8'd0, 0);
    add_op(imh_pkg::OP_PUSH, 8'd77, 3);
    wait (pending_ops.size() == 0);
    calm = 0;
    add_op(imh_pkg::OP_CLEAR, 8'd0, 0);

    // Random: pushes most often, over a small id pool so ids collide and stay live.
    for (int i = 0; i < 170; i++) begin
      if (i == 60) begin
        wait (pending_ops.size() == 0);
        calm = 1;
      end
      if (i == 120) begin
        wait (pending_ops.size() == 0);
        calm = 0;
      end
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 40));
      r = $urandom_range(0, 99);
      if (r < 40) add_op(imh_pkg::OP_PUSH, id, rand_prio());
      else if (r < 55) add_op(imh_pkg::OP_POP, id, $urandom());
      else if (r < 65) add_op(imh_pkg::OP_DEACT, id, $urandom());
      else if (r < 85) add_op(imh_pkg::OP_MODIFY, id, rand_prio());
      else if (r < 87) add_op(imh_pkg::OP_CLEAR, id, $urandom());
      else add_op(3'($urandom_range(5, 7)), id, $urandom());
    end
    wait (pending_ops.size() == 0 && !in_valid_i);
    stim_done = 1;
    wait (expected_views.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("ran %0d result beats: directed extremes, full heap, random mix", n_results);
    if (n_errors == 0) begin
      $display("indexed_max_heap_unit: match");
    end else begin
      $display("%0d mismatched fields", n_errors);
      $display("indexed_max_heap_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/imh_pkg.sv
rtl/core/imh_ram.sv
rtl/core/indexed_max_heap_unit.sv
sim/indexed_max_heap_unit_test.sv
